// File: design/bsc_pkg.sv
// Package for the background subtraction cell counter.
// Holds sizes, register indexes, reset values and the item structs.
// No dependencies; every design file but bsc_ram uses it by scoped names.
package bsc_pkg;

    localparam int PIXEL_COUNT   = 16384;
    localparam int ADDR_W        = $clog2(PIXEL_COUNT);
    localparam int MAX_CELL_SIZE = 32;
    localparam int COL_W         = $clog2(MAX_CELL_SIZE);
    localparam int COUNT_W       = 11;
    localparam int FAST_FACTOR   = 3;

    localparam logic [COUNT_W-1:0] COUNTER_MAX = {COUNT_W{1'b1}};

    // Output queue sizing.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY     = 2'd2;

    localparam logic [7:0] THRESHOLD_RESET = 8'd16;
    localparam logic [7:0] RATE_RESET      = 8'd1;
    localparam logic [7:0] DELAY_RESET     = 8'd10;

    // Item functions.
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_PROCESS = 1'b1;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] pixel_address;
        logic [7:0]        pixel_value;
        logic [COL_W-1:0]  cell_column;
        logic              cell_first_row;
        logic              cell_last;
    } pixel_item_t;

    typedef struct packed {
        logic               motion_mark;
        logic [COUNT_W-1:0] cell_count;
        logic               cell_done;
    } result_item_t;

    typedef struct packed {
        logic [7:0] threshold;
        logic [7:0] rate;
        logic [7:0] delay;
    } cfg_regs_t;

    typedef struct packed {
        logic       counted;
        logic       mark;
        logic       bg_we;
        logic [7:0] bg_next;
        logic [7:0] cnt_next;
    } upd_result_t;

endpackage

// File: design/background_subtract_cell_counter.sv
// Top level of the background subtraction cell counter.
// Depends on bsc_pkg, bsc_ram, bsc_update and bsc_out_fifo.
//
// Usage: configuration writes arrive on the cfg_ channel (index 0 threshold,
// 1 update rate, 2 update delay) and are always taken; they are meant to be
// issued only while no item is in flight. Input items on the s_ channel either
// load one background byte or process one pixel. Each process item yields one
// result item on the m_ channel; a load item yields none.
// A result is registered in the stage and then in the output queue.
// Throughput: one item per clock while s_ready is high, limited by the single
// read-modify-write pass through the two pixel memories (read at acceptance,
// write in the cycle after). After reset the change-count memory is cleared,
// one entry per cycle through all 16384 entries; s_ready stays low during that pass.
// When the receiver stalls, results collect in a four-entry queue and s_ready
// drops once the queue could not absorb the item already in the pipeline plus
// a new one, so no result is ever lost.
module background_subtract_cell_counter (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  bsc_pkg::pixel_item_t               s_item,
    output logic                               m_valid,
    input  logic                               m_ready,
    output bsc_pkg::result_item_t              m_item,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [7:0]                         cfg_data
);

    // Configuration registers.
    bsc_pkg::cfg_regs_t cfg_reg, cfg_next;

    // Pipeline stage holding the item whose memory data is now available.
    logic                  s1_valid_reg;
    bsc_pkg::pixel_item_t  s1_item_reg;
    logic                  s1_proc;

    // Clearing pass over the change-count memory.
    logic                         clearing_reg, clearing_next;
    logic [bsc_pkg::ADDR_W-1:0]   clr_addr_reg, clr_addr_next;

    // Forwarding of the latest write to each memory. The memories return
    // the old value when read and written at the same edge, so the stage
    // picks the newer byte from these registers when the address matches.
    logic                         bg_fwd_valid_reg;
    logic [bsc_pkg::ADDR_W-1:0]   bg_fwd_addr_reg;
    logic [7:0]                   bg_fwd_data_reg;
    logic                         cnt_fwd_valid_reg;
    logic [bsc_pkg::ADDR_W-1:0]   cnt_fwd_addr_reg;
    logic [7:0]                   cnt_fwd_data_reg;

    // Neighbour marks and the running cell count.
    logic [bsc_pkg::MAX_CELL_SIZE-1:0] upper_marks_reg, upper_marks_next;
    logic                              left_mark_reg, left_mark_next;
    logic [bsc_pkg::COUNT_W-1:0]       motion_cnt_reg, motion_cnt_next;
    logic [bsc_pkg::COUNT_W-1:0]       cell_count;

    // Memory ports.
    logic                         bg_we;
    logic [7:0]                   bg_wdata;
    logic [7:0]                   bg_rdata;
    logic                         cnt_we;
    logic [bsc_pkg::ADDR_W-1:0]   cnt_waddr;
    logic [7:0]                   cnt_wdata;
    logic [7:0]                   cnt_rdata;

    logic [7:0]                   bg_cur;
    logic [7:0]                   cnt_cur;
    logic                         up_mark;
    logic                         left_mark;
    bsc_pkg::upd_result_t         upd;
    bsc_pkg::result_item_t        result;
    logic [bsc_pkg::OUT_CNT_W-1:0] fifo_count;
    logic                         s_accept;

    // ------------------------------------------------------------------
    // Configuration port: always ready, writes beyond the list are dropped.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                bsc_pkg::CFG_THRESHOLD: cfg_next.threshold = cfg_data;
                bsc_pkg::CFG_RATE:      cfg_next.rate      = cfg_data;
                bsc_pkg::CFG_DELAY:     cfg_next.delay     = cfg_data;
                default:                cfg_next           = cfg_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input acceptance. The queue must have room for the item already in
    // the stage and for the one being accepted.
    // ------------------------------------------------------------------
    assign s_ready  = !clearing_reg &&
                      ((fifo_count + bsc_pkg::OUT_CNT_W'(s1_valid_reg)) <
                       bsc_pkg::OUT_CNT_W'(bsc_pkg::OUT_DEPTH));
    assign s_accept = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Pixel memories, both read at the address of the item being accepted.
    // ------------------------------------------------------------------
    bsc_ram #(
        .DATA_W (8),
        .ADDR_W (bsc_pkg::ADDR_W)
    ) u_bg_ram (
        .aclk  (aclk),
        .we    (bg_we),
        .waddr (s1_item_reg.pixel_address),
        .wdata (bg_wdata),
        .raddr (s_item.pixel_address),
        .rdata (bg_rdata)
    );

    bsc_ram #(
        .DATA_W (8),
        .ADDR_W (bsc_pkg::ADDR_W)
    ) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (s_item.pixel_address),
        .rdata (cnt_rdata)
    );

    // ------------------------------------------------------------------
    // Stage: forward, decide, write back.
    // ------------------------------------------------------------------
    always_comb begin
        s1_proc = s1_valid_reg && (s1_item_reg.func == bsc_pkg::FUNC_PROCESS);

        bg_cur  = (bg_fwd_valid_reg && bg_fwd_addr_reg == s1_item_reg.pixel_address)
                  ? bg_fwd_data_reg : bg_rdata;
        cnt_cur = (cnt_fwd_valid_reg && cnt_fwd_addr_reg == s1_item_reg.pixel_address)
                  ? cnt_fwd_data_reg : cnt_rdata;

        // Cell edges: no upper neighbour in the first row, no left one in
        // column zero.
        up_mark   = !s1_item_reg.cell_first_row && upper_marks_reg[s1_item_reg.cell_column];
        left_mark = (s1_item_reg.cell_column != '0) && left_mark_reg;
    end

    bsc_update u_update (
        .pixel_value  (s1_item_reg.pixel_value),
        .bg_value     (bg_cur),
        .change_count (cnt_cur),
        .cfg          (cfg_reg),
        .up_mark      (up_mark),
        .left_mark    (left_mark),
        .res          (upd)
    );

    always_comb begin
        // A load item writes the pixel itself; a process item writes the
        // moved background when the decision asks for it.
        bg_we    = s1_valid_reg &&
                   ((s1_item_reg.func == bsc_pkg::FUNC_LOAD) || upd.bg_we);
        bg_wdata = (s1_item_reg.func == bsc_pkg::FUNC_LOAD) ?
                   s1_item_reg.pixel_value : upd.bg_next;

        if (clearing_reg) begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_addr_reg;
            cnt_wdata = 8'd0;
        end else begin
            cnt_we    = s1_proc;
            cnt_waddr = s1_item_reg.pixel_address;
            cnt_wdata = upd.cnt_next;
        end

        // The counter saturates rather than wrapping when no last pixel comes.
        cell_count = motion_cnt_reg;
        if (upd.counted && motion_cnt_reg != bsc_pkg::COUNTER_MAX) begin
            cell_count = motion_cnt_reg + 1'b1;
        end

        upper_marks_next = upper_marks_reg;
        left_mark_next   = left_mark_reg;
        motion_cnt_next  = motion_cnt_reg;
        if (s1_proc) begin
            upper_marks_next[s1_item_reg.cell_column] = upd.mark;
            left_mark_next  = upd.mark;
            motion_cnt_next = s1_item_reg.cell_last ? '0 : cell_count;
        end

        result.motion_mark = upd.counted;
        result.cell_count  = cell_count;
        result.cell_done   = s1_item_reg.cell_last;

        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == bsc_pkg::ADDR_W'(bsc_pkg::PIXEL_COUNT - 1)) begin
                clearing_next = 1'b0;
            end
        end
    end

    bsc_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s1_proc),
        .push_item (result),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .count     (fifo_count)
    );

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold <= bsc_pkg::THRESHOLD_RESET;
            cfg_reg.rate      <= bsc_pkg::RATE_RESET;
            cfg_reg.delay     <= bsc_pkg::DELAY_RESET;
            s1_valid_reg      <= 1'b0;
            clearing_reg      <= 1'b1;
            clr_addr_reg      <= '0;
            bg_fwd_valid_reg  <= 1'b0;
            cnt_fwd_valid_reg <= 1'b0;
            upper_marks_reg   <= '0;
            left_mark_reg     <= 1'b0;
            motion_cnt_reg    <= '0;
        end else begin
            cfg_reg         <= cfg_next;
            s1_valid_reg    <= s_accept;
            clearing_reg    <= clearing_next;
            clr_addr_reg    <= clr_addr_next;
            upper_marks_reg <= upper_marks_next;
            left_mark_reg   <= left_mark_next;
            motion_cnt_reg  <= motion_cnt_next;
            if (bg_we) begin
                bg_fwd_valid_reg <= 1'b1;
            end
            if (cnt_we && !clearing_reg) begin
                cnt_fwd_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_item_reg <= s_item;
        end
        if (bg_we) begin
            bg_fwd_addr_reg <= s1_item_reg.pixel_address;
            bg_fwd_data_reg <= bg_wdata;
        end
        if (cnt_we) begin
            cnt_fwd_addr_reg <= cnt_waddr;
            cnt_fwd_data_reg <= cnt_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !s_ready)
        else $error("item accepted during the clearing pass");

    a_fifo_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (fifo_count + bsc_pkg::OUT_CNT_W'(s1_valid_reg)) <=
        bsc_pkg::OUT_CNT_W'(bsc_pkg::OUT_DEPTH))
        else $error("result queue could overflow");

    a_count_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_proc && s1_item_reg.cell_last) |=> (motion_cnt_reg == '0))
        else $error("cell count not restarted after the last pixel");

    a_clear_writes_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> (cnt_we && cnt_wdata == 8'd0 && !s1_valid_reg))
        else $error("clearing pass disturbed");

endmodule

// File: design/bsc_ram.sv
// Generic simple dual-port RAM with one write and one registered read port.
// Uses no package; sized by its parameters.
module bsc_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 14
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/bsc_update.sv
// Per-pixel decision: threshold test, change counter and background step.
// Depends on bsc_pkg for the config and result structs and FAST_FACTOR.
module bsc_update (
    input  logic [7:0]                pixel_value,
    input  logic [7:0]                bg_value,
    input  logic [7:0]                change_count,
    input  bsc_pkg::cfg_regs_t        cfg,
    input  logic                      up_mark,
    input  logic                      left_mark,
    output bsc_pkg::upd_result_t      res
);

    logic       above;
    logic       below;
    logic [7:0] mag;
    logic       quiet;
    logic [7:0] cnt_inc;
    logic [7:0] step;
    logic [7:0] bg_moved;

    always_comb begin
        above   = pixel_value > bg_value;
        below   = pixel_value < bg_value;
        mag     = above ? (pixel_value - bg_value) : (bg_value - pixel_value);
        quiet   = mag < cfg.threshold;
        cnt_inc = change_count + 8'd1;

        // A quiet pixel takes a single step, a persistent change a faster one.
        step = quiet ? cfg.rate : 8'(cfg.rate * bsc_pkg::FAST_FACTOR);
        if (above) begin
            bg_moved = bg_value + step;
        end else if (below) begin
            bg_moved = bg_value - step;
        end else begin
            bg_moved = bg_value;
        end

        res.counted  = quiet ? (up_mark && left_mark) : 1'b1;
        res.mark     = res.counted && (pixel_value != 8'd0);
        res.bg_we    = quiet || (cnt_inc > cfg.delay);
        res.bg_next  = bg_moved;
        res.cnt_next = quiet ? 8'd0 : cnt_inc;
    end

endmodule

// File: design/bsc_out_fifo.sv
// Small result queue that decouples the pipeline from the receiver.
// Depends on bsc_pkg for the result struct and queue sizing.
module bsc_out_fifo (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                push,
    input  bsc_pkg::result_item_t               push_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output bsc_pkg::result_item_t               m_item,
    output logic [bsc_pkg::OUT_CNT_W-1:0]       count
);

    bsc_pkg::result_item_t               slot_reg [bsc_pkg::OUT_DEPTH];
    logic [bsc_pkg::OUT_PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [bsc_pkg::OUT_PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [bsc_pkg::OUT_CNT_W-1:0]       count_reg, count_next;
    logic                                pop;

    always_comb begin
        pop         = m_valid && m_ready;
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign m_valid = count_reg != '0;
    assign m_item  = slot_reg[rd_ptr_reg];
    assign count   = count_reg;

endmodule

// File: dv/background_subtract_cell_counter_test.sv
// Self-checking testbench for background_subtract_cell_counter.
// Needs bsc_pkg and the design sources only. A built-in model of the background
// and the change counts predicts every result, and the results are checked in order.
`timescale 1ns / 1ps

module background_subtract_cell_counter_test;
    import bsc_pkg::*;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DIRECTED_BASE   = 100;
    localparam int SATURATE_ITEMS  = 2050;
    localparam int PHASE_ITEMS     = 100;

    logic           aclk;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    pixel_item_t    s_item;
    logic           m_valid;
    logic           m_ready;
    result_item_t   m_item;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]     cfg_data;

    // Predicted state of the block.
    cfg_regs_t          cfg_model;
    logic [7:0]         bg_model [PIXEL_COUNT];
    bit                 bg_written [PIXEL_COUNT];
    bit [7:0]           change_model [PIXEL_COUNT];
    bit                 marks_above [MAX_CELL_SIZE];
    bit                 left_mark;
    logic [COUNT_W-1:0] count_model;

    result_item_t expected_results [$];
    int           loaded_list [$];
    int           cell_bases [8];
    int           items_sent;
    int           fail_count;
    int           send_idle_pct;
    int           recv_stall_pct;
    bit           hold_off_req;

    background_subtract_cell_counter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Updates the model with one accepted item. Returns 1 when the item yields a result.
    function automatic bit predict_pixel(input pixel_item_t it, output result_item_t res);
        logic [7:0] bg;
        logic [7:0] mag;
        logic [7:0] step;
        logic [7:0] cnt;
        bit         counted;
        bit         mark;
        int         addr;
        int         col;
        res  = '0;
        addr = it.pixel_address;
        col  = it.cell_column;
        if (it.func == FUNC_LOAD) begin
            bg_model[addr] = it.pixel_value;
            if (!bg_written[addr]) begin
                bg_written[addr] = 1'b1;
                loaded_list.push_back(addr);
            end
            return 1'b0;
        end
        bg  = bg_model[addr];
        mag = (it.pixel_value >= bg) ? it.pixel_value - bg : bg - it.pixel_value;
        if (mag < cfg_model.threshold) begin
            // A quiet pixel counts only inside a marked neighbourhood.
            counted = !it.cell_first_row && marks_above[col] && col != 0 && left_mark;
            change_model[addr] = 8'd0;
            step = cfg_model.rate;
        end else begin
            cnt = change_model[addr] + 8'd1;
            change_model[addr] = cnt;
            counted = 1'b1;
            step = (cnt > cfg_model.delay) ? 8'(cfg_model.rate * FAST_FACTOR) : 8'd0;
        end
        if (it.pixel_value > bg) begin
            bg_model[addr] = bg + step;
        end else if (it.pixel_value < bg) begin
            bg_model[addr] = bg - step;
        end
        mark = counted && it.pixel_value != 8'd0;
        marks_above[col] = mark;
        left_mark = mark;
        if (counted && count_model != COUNTER_MAX) begin
            count_model++;
        end
        res.motion_mark = counted;
        res.cell_count  = count_model;
        res.cell_done   = it.cell_last;
        if (it.cell_last) begin
            count_model = '0;
        end
        return 1'b1;
    endfunction

    function automatic pixel_item_t pix_item(input logic func_code, input int addr,
                                             input int value, input int col,
                                             input bit first_row, input bit last);
        pixel_item_t it;
        it.func           = func_code;
        it.pixel_address  = addr[ADDR_W-1:0];
        it.pixel_value    = value[7:0];
        it.cell_column    = col[COL_W-1:0];
        it.cell_first_row = first_row;
        it.cell_last      = last;
        return it;
    endfunction

    // Offers one item after a random gap and predicts it once it is taken.
    task automatic send_pixel(input pixel_item_t it);
        result_item_t res;
        @(negedge aclk);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (predict_pixel(it, res)) begin
            expected_results.push_back(res);
        end
    endtask

    // Lowers valid and waits for every outstanding result and the pipeline tail.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_THRESHOLD: cfg_model.threshold = value;
            CFG_RATE:      cfg_model.rate      = value;
            CFG_DELAY:     cfg_model.delay     = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] threshold, input logic [7:0] rate,
                              input logic [7:0] delay);
        write_register(CFG_THRESHOLD, threshold);
        write_register(CFG_RATE, rate);
        write_register(CFG_DELAY, delay);
    endtask

    // One well-formed cell in raster order. Missing background entries are
    // loaded first, and most pixels sit close to the background.
    task automatic send_cell(input int width, input int height);
        int         base;
        int         addr;
        logic [7:0] value;
        base = cell_bases[$urandom_range(7)];
        for (int r = 0; r < height; r++) begin
            for (int c = 0; c < width; c++) begin
                addr = (base + r * MAX_CELL_SIZE + c) % PIXEL_COUNT;
                if (!bg_written[addr]) begin
                    send_pixel(pix_item(FUNC_LOAD, addr, $urandom, $urandom, 1'($urandom),
                                        1'($urandom)));
                end
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: value = 8'(bg_model[addr] + $urandom_range(48) - 24);
                    6, 7, 8:          value = 8'($urandom);
                    default:          value = $urandom_range(1) ? 8'd255 : 8'd0;
                endcase
                send_pixel(pix_item(FUNC_PROCESS, addr, value, c, r == 0,
                                    r == height - 1 && c == width - 1));
            end
        end
    endtask

    // Reset register values; extremes of the fields and the edges of a cell.
    task automatic test_directed_edges();
        send_pixel(pix_item(FUNC_LOAD, 0, 0, 0, 0, 0));
        send_pixel(pix_item(FUNC_LOAD, PIXEL_COUNT - 1, 255, 31, 1, 1));
        for (int i = 0; i < 6; i++) begin
            send_pixel(pix_item(FUNC_LOAD, DIRECTED_BASE + i, 50, 0, 0, 0));
        end
        // First row: two moving pixels, then a moving black pixel that leaves no mark.
        send_pixel(pix_item(FUNC_PROCESS, DIRECTED_BASE,     200, 0, 1, 0));
        send_pixel(pix_item(FUNC_PROCESS, DIRECTED_BASE + 1, 200, 1, 1, 0));
        send_pixel(pix_item(FUNC_PROCESS, DIRECTED_BASE + 2, 0,   2, 1, 0));
        // Second row: a quiet pixel with both neighbours marked still counts,
        // the one under the black pixel does not.
        send_pixel(pix_item(FUNC_PROCESS, DIRECTED_BASE + 3, 255, 0, 0, 0));
        send_pixel(pix_item(FUNC_PROCESS, DIRECTED_BASE + 4, 52,  1, 0, 0));
        send_pixel(pix_item(FUNC_PROCESS, DIRECTED_BASE + 5, 48,  2, 0, 1));
        // Exact match at the lowest address, then the top address at full scale.
        send_pixel(pix_item(FUNC_PROCESS, 0, 0, 31, 0, 0));
        send_pixel(pix_item(FUNC_PROCESS, PIXEL_COUNT - 1, 255, 31, 1, 0));
        send_pixel(pix_item(FUNC_PROCESS, PIXEL_COUNT - 1, 0, 31, 0, 1));
    endtask

    // With a zero threshold every pixel is motion; a cell far too long drives the
    // counter into saturation, and the change counts wrap along the way.
    task automatic test_counter_saturation();
        wait_idle();
        set_config(8'd0, 8'd0, 8'd255);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i <= SATURATE_ITEMS; i++) begin
            send_pixel(pix_item(FUNC_PROCESS, DIRECTED_BASE + i % 4, $urandom,
                                i % MAX_CELL_SIZE, 1'($urandom), i >= SATURATE_ITEMS - 1));
        end
    endtask

    // Mostly well-formed cells, with stray loads and stray pixels mixed in.
    task automatic test_random_traffic(input logic [7:0] threshold, input logic [7:0] rate,
                                       input logic [7:0] delay, input int idle_pct,
                                       input int stall_pct, input int item_goal);
        int start;
        int pick;
        int width;
        wait_idle();
        set_config(threshold, rate, delay);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = items_sent;
        while (items_sent - start < item_goal) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                send_pixel(pix_item(FUNC_LOAD, $urandom_range(PIXEL_COUNT - 1), $urandom,
                                    $urandom, 1'($urandom), 1'($urandom)));
            end else if (pick < 12) begin
                send_pixel(pix_item(FUNC_PROCESS,
                                    loaded_list[$urandom_range(loaded_list.size() - 1)],
                                    $urandom, $urandom, 1'($urandom), 1'($urandom)));
            end else if (pick < 18) begin
                width = $urandom_range(MAX_CELL_SIZE, 9);
                send_cell(width, $urandom_range(2, 1));
            end else begin
                send_cell($urandom_range(8, 2), $urandom_range(4, 1));
            end
        end
    endtask

    // The receiver holds off for a long stretch while a full cell is offered,
    // so the result queue fills and the input has to stall.
    task automatic test_output_backpressure();
        wait_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_req   = 1'b1;
        send_cell(8, 4);
    endtask

    // Receiver: random stalls, plus a long hold-off counted here on request.
    initial begin : receiver_ready
        int hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_left    = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Every accepted result is matched against the oldest prediction.
    always @(posedge aclk) begin : check_results
        result_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no item pending: %p", m_item);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_item.motion_mark !== want.motion_mark) begin
                    $error("motion_mark: expected %0d, got %0d", want.motion_mark,
                           m_item.motion_mark);
                    fail_count++;
                end
                if (m_item.cell_count !== want.cell_count) begin
                    $error("cell_count: expected %0d, got %0d", want.cell_count,
                           m_item.cell_count);
                    fail_count++;
                end
                if (m_item.cell_done !== want.cell_done) begin
                    $error("cell_done: expected %0d, got %0d", want.cell_done,
                           m_item.cell_done);
                    fail_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) begin
            @(posedge aclk);
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_item    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_THRESHOLD;
        cfg_data  = 8'd0;
        cfg_model.threshold = THRESHOLD_RESET;
        cfg_model.rate      = RATE_RESET;
        cfg_model.delay     = DELAY_RESET;
        count_model    = '0;
        left_mark      = 1'b0;
        items_sent     = 0;
        fail_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_req   = 1'b0;
        foreach (cell_bases[i]) begin
            cell_bases[i] = $urandom_range(PIXEL_COUNT - 1);
        end
        cell_bases[0] = 0;
        cell_bases[1] = PIXEL_COUNT - 2 * MAX_CELL_SIZE;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // The block clears its change counts after reset; the first item waits for that.
        test_directed_edges();
        test_counter_saturation();
        test_random_traffic(8'($urandom_range(40, 8)), 8'($urandom_range(8, 1)),
                            8'($urandom_range(15)), 0, 0, PHASE_ITEMS);
        test_random_traffic(8'd255, 8'd255, 8'd0, 88, 0, PHASE_ITEMS);
        test_random_traffic(8'd1, 8'd128, 8'd255, 0, 88, PHASE_ITEMS);
        test_output_backpressure();
        test_random_traffic(8'($urandom), 8'($urandom), 8'($urandom), 13, 13, PHASE_ITEMS);
        wait_idle();

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
